FILE: rtl/swmq_pkg.sv
// swmq_pkg: shared types and constants of the sliding window maximum queue
// depends on nothing
`default_nettype none

package swmq_pkg;

    localparam int WINDOW_LIMIT_DEF = 1024;
    localparam int SAMPLE_BITS_DEF  = 32;
    localparam int SAMPLE_W         = 32;
    localparam int DROP_W           = 11;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DROP
    } state_t;

    // broadcast command to every cell
    typedef struct packed {
        logic push;
        logic shift;
        logic clear;
    } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/swmq_if.sv
// swmq_in_if, swmq_out_if: valid/ready channels of the queue
// depends on swmq_pkg
`default_nettype none

interface swmq_in_if;
    logic                           valid;
    logic                           ready;
    logic [swmq_pkg::SAMPLE_W-1:0]  sample;
    logic [swmq_pkg::DROP_W-1:0]    drop_count;

    modport source (output valid, sample, drop_count, input ready);
    modport sink   (input valid, sample, drop_count, output ready);
endinterface

interface swmq_out_if;
    logic                           valid;
    logic                           ready;
    logic [swmq_pkg::SAMPLE_W-1:0]  window_max;
    logic                           window_empty;
    logic                           overflow;

    modport source (output valid, window_max, window_empty, overflow, input ready);
    modport sink   (input valid, window_max, window_empty, overflow, output ready);
endinterface

`default_nettype wire

FILE: rtl/swmq_cell.sv
// swmq_cell: one queue entry with value, arrival stamp and valid bit
// depends on swmq_pkg
`default_nettype none

module swmq_cell #(
    parameter int SAMPLE_BITS = 32,
    parameter int STAMP_W     = 11
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire swmq_pkg::cell_cmd_t    cmd,
    input  wire logic [SAMPLE_BITS-1:0] push_value,
    input  wire logic [STAMP_W-1:0]     push_stamp,
    input  wire logic                   prev_survive,
    input  wire logic                   next_valid,
    input  wire logic [SAMPLE_BITS-1:0] next_value,
    input  wire logic [STAMP_W-1:0]     next_stamp,
    output logic                        valid,
    output logic [SAMPLE_BITS-1:0]      value,
    output logic [STAMP_W-1:0]          stamp,
    output logic                        survive
);
    import swmq_pkg::*;

    logic                   valid_reg, valid_next;
    logic [SAMPLE_BITS-1:0] value_reg, value_next;
    logic [STAMP_W-1:0]     stamp_reg, stamp_next;

    // entries strictly decrease toward the tail, so survivors form a prefix
    assign survive = valid_reg && (value_reg > push_value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        stamp_next = stamp_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.push)
        begin
            if (!survive)
            begin
                valid_next = prev_survive;
                value_next = push_value;
                stamp_next = push_stamp;
            end
        end
        else if (cmd.shift)
        begin
            valid_next = next_valid;
            value_next = next_value;
            stamp_next = next_stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        stamp_reg <= stamp_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign stamp = stamp_reg;

endmodule

`default_nettype wire

FILE: rtl/sliding_window_max_queue_core.sv
// sliding_window_max_queue_core: windowed maximum over a row of queue cells
// depends on swmq_pkg, swmq_if, swmq_cell
// result: the accepting edge moves to ST_DROP, which shifts out each entry leaving the head,
// then loads the result register; one item at a time, a new one is taken only in ST_IDLE,
// and a result not yet taken holds the next result back
// reset clears all valid bits and counters at once, no clearing pass
`default_nettype none

module sliding_window_max_queue_core #(
    parameter int WINDOW_LIMIT = swmq_pkg::WINDOW_LIMIT_DEF,
    parameter int SAMPLE_BITS  = swmq_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    swmq_in_if.sink    samples,
    swmq_out_if.source results
);
    import swmq_pkg::*;

    // stamps and held count cover up to the limit itself
    localparam int STAMP_W = $clog2(WINDOW_LIMIT + 1);
    localparam int HP_W    = STAMP_W + 1;
    localparam int CMP_W   = (HP_W > DROP_W) ? HP_W : DROP_W;

    state_t              state_reg, state_next;
    logic [STAMP_W-1:0]  held_reg, held_next;
    logic [STAMP_W-1:0]  stamp_cnt_reg, stamp_cnt_next;
    logic [STAMP_W-1:0]  newest_reg, newest_next;
    logic                ovf_reg, ovf_next;

    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_max_reg, out_max_next;
    logic                out_empty_reg, out_empty_next;
    logic                out_ovf_reg, out_ovf_next;

    cell_cmd_t           cmd;
    logic                accept;
    logic                ovf_now;
    logic                empties;
    logic                out_of_win;
    logic                finish;
    logic                slot_free;
    logic [HP_W-1:0]     held_p;
    logic [CMP_W-1:0]    held_after;
    logic [SAMPLE_BITS-1:0] push_value;

    // cell row, entry 0 is the oldest (head)
    logic                   c_valid   [WINDOW_LIMIT];
    logic [SAMPLE_BITS-1:0] c_value   [WINDOW_LIMIT];
    logic [STAMP_W-1:0]     c_stamp   [WINDOW_LIMIT];
    logic                   c_survive [WINDOW_LIMIT];

    // sample masked to the sample width
    assign push_value = SAMPLE_BITS'(samples.sample);

    assign held_p     = HP_W'(held_reg) + HP_W'(1);
    assign ovf_now    = held_p > HP_W'(WINDOW_LIMIT);
    // a drop reaching every held sample empties the window
    assign empties    = CMP_W'(samples.drop_count) >= CMP_W'(held_p);
    assign held_after = CMP_W'(held_p) - CMP_W'(samples.drop_count);
    assign accept     = samples.valid && samples.ready;
    assign slot_free  = !out_valid_reg || results.ready;

    // head leaves when its age reaches the held count
    assign out_of_win = (held_reg != '0) && !ovf_reg &&
                        (STAMP_W'(newest_reg - c_stamp[0]) >= held_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DROP;
                end
            end
            ST_DROP:
            begin
                if (!out_of_win && slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        samples.ready = 1'b0;
        cmd           = '0;
        finish        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
                cmd.push      = samples.valid && !ovf_now && !empties;
                cmd.clear     = samples.valid && !ovf_now && empties;
            end
            ST_DROP:
            begin
                cmd.shift = out_of_win;
                finish    = !out_of_win && slot_free;
            end
            default:
            begin
                samples.ready = 1'b0;
            end
        endcase
    end

    // counters
    always_comb
    begin
        held_next      = held_reg;
        stamp_cnt_next = stamp_cnt_reg;
        newest_next    = newest_reg;
        ovf_next       = ovf_reg;
        if (accept)
        begin
            ovf_next = ovf_now;
        end
        if (cmd.push)
        begin
            held_next      = STAMP_W'(held_after);
            newest_next    = stamp_cnt_reg;
            stamp_cnt_next = stamp_cnt_reg + STAMP_W'(1);
        end
        else if (cmd.clear)
        begin
            held_next      = '0;
            stamp_cnt_next = '0;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_max_next   = out_max_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
            out_empty_next = !c_valid[0];
            out_max_next   = c_valid[0] ? SAMPLE_W'(c_value[0]) : '0;
            out_ovf_next   = ovf_reg;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            stamp_cnt_reg <= '0;
            newest_reg    <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            stamp_cnt_reg <= stamp_cnt_next;
            newest_reg    <= newest_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_max_reg   <= out_max_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.window_max   = out_max_reg;
    assign results.window_empty = out_empty_reg;
    assign results.overflow     = out_ovf_reg;

    // row of cells: push writes the first place after the survivors and empties the places behind it,
    // shift moves every entry one place toward the head
    for (genvar i = 0; i < WINDOW_LIMIT; i++)
    begin : g_cell
        logic                   prev_s;
        logic                   nxt_v;
        logic [SAMPLE_BITS-1:0] nxt_val;
        logic [STAMP_W-1:0]     nxt_st;

        if (i == 0)
        begin : g_first
            assign prev_s = 1'b1;
        end
        else
        begin : g_mid
            assign prev_s = c_survive[i-1];
        end

        if (i == WINDOW_LIMIT - 1)
        begin : g_last
            assign nxt_v   = 1'b0;
            assign nxt_val = '0;
            assign nxt_st  = '0;
        end
        else
        begin : g_inner
            assign nxt_v   = c_valid[i+1];
            assign nxt_val = c_value[i+1];
            assign nxt_st  = c_stamp[i+1];
        end

        swmq_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .STAMP_W     (STAMP_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .push_value   (push_value),
            .push_stamp   (stamp_cnt_reg),
            .prev_survive (prev_s),
            .next_valid   (nxt_v),
            .next_value   (nxt_val),
            .next_stamp   (nxt_st),
            .valid        (c_valid[i]),
            .value        (c_value[i]),
            .stamp        (c_stamp[i]),
            .survive      (c_survive[i])
        );
    end

endmodule

`default_nettype wire

FILE: bench/tb.sv
// tb: self-checking bench for sliding_window_max_queue_core
// depends on swmq_pkg, swmq_if and the core itself
`timescale 1ns / 1ps

module tb;

    import swmq_pkg::*;

    localparam int LIMIT      = WINDOW_LIMIT_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] window_max;
        logic                window_empty;
        logic                overflow;
    } window_result_t;

    logic clk;
    logic rst_n;

    swmq_in_if  samples ();
    swmq_out_if results ();

    sliding_window_max_queue_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples.sink),
        .results (results.source)
    );

    // clock, 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // own copy of the monotonic queue: values strictly fall from head to tail
    logic [SAMPLE_W-1:0] q_value [LIMIT];
    int unsigned         q_run   [LIMIT];
    int unsigned         q_head;
    int unsigned         q_tail;
    int unsigned         q_entries;
    int unsigned         q_held;

    window_result_t expected_windows [$];

    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned overflows_seen;
    int unsigned empties_seen;
    int unsigned errors;
    int unsigned idle_cycles;
    int unsigned burst_left;

    // work out the window after one item and queue the expected result
    task automatic predict_window(input logic [SAMPLE_W-1:0] value,
                                  input logic [DROP_W-1:0] drop);
        int unsigned    remaining;
        int unsigned    folded;
        int unsigned    last;
        window_result_t res;
        remaining = drop;
        folded    = 0;
        res.overflow = 1'b0;
        if (q_held + 1 > LIMIT)
        begin
            // item refused, queue untouched
            res.overflow = 1'b1;
        end
        else
        begin
            // fold every tail entry at or below the new sample
            while (q_entries > 0)
            begin
                last = (q_tail == 0) ? LIMIT - 1 : q_tail - 1;
                if (q_value[last] > value)
                    break;
                folded += q_run[last];
                q_tail = last;
                q_entries--;
            end
            q_value[q_tail] = value;
            q_run[q_tail]   = folded + 1;
            q_tail          = (q_tail + 1) % LIMIT;
            q_entries++;
            q_held++;
            // whole runs leave the head, a partial run shrinks
            while (q_entries > 0 && remaining >= q_run[q_head])
            begin
                remaining -= q_run[q_head];
                q_held    -= q_run[q_head];
                q_head     = (q_head + 1) % LIMIT;
                q_entries--;
            end
            if (q_entries > 0)
            begin
                q_run[q_head] -= remaining;
                q_held        -= remaining;
            end
            else
            begin
                q_head = 0;
                q_tail = 0;
                q_held = 0;
            end
        end
        if (q_entries > 0)
        begin
            res.window_max   = q_value[q_head];
            res.window_empty = 1'b0;
        end
        else
        begin
            res.window_max   = '0;
            res.window_empty = 1'b1;
        end
        expected_windows.push_back(res);
    endtask

    // send one item; the sender works in bursts with random gaps
    task automatic send_item(input logic [SAMPLE_W-1:0] value,
                             input logic [DROP_W-1:0] drop);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                samples.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        samples.valid      <= 1'b1;
        samples.sample     <= value;
        samples.drop_count <= drop;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        predict_window(value, drop);
        items_sent++;
    endtask

    task automatic pause_sender();
        samples.valid <= 1'b0;
        @(posedge clk);
        while (expected_windows.size() != 0)
            @(posedge clk);
    endtask

    // receiver stall pattern: phases of always ready, random and mostly stalled
    int unsigned stall_mode;
    int unsigned stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            stall_mode    <= 0;
            stall_left    <= 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(5, 80);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                0:       results.ready <= 1'b1;
                1:       results.ready <= 1'($urandom_range(0, 1));
                default: results.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            window_result_t exp_res;
            if (expected_windows.size() == 0)
            begin
                $display("%0t: result with nothing expected, max %h empty %b ovf %b",
                         $time, results.window_max, results.window_empty,
                         results.overflow);
                errors++;
            end
            else
            begin
                exp_res = expected_windows.pop_front();
                results_seen++;
                if (exp_res.overflow)
                    overflows_seen++;
                if (exp_res.window_empty)
                    empties_seen++;
                if (results.window_max !== exp_res.window_max)
                begin
                    $display("%0t: window_max expected %h actual %h",
                             $time, exp_res.window_max, results.window_max);
                    errors++;
                end
                if (results.window_empty !== exp_res.window_empty)
                begin
                    $display("%0t: window_empty expected %b actual %b",
                             $time, exp_res.window_empty, results.window_empty);
                    errors++;
                end
                if (results.overflow !== exp_res.overflow)
                begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, exp_res.overflow, results.overflow);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // edges of the fields, folding of equal samples, partial and oversize drops
    task automatic test_directed();
        send_item(32'h0000_0000, 11'd1);        // empty window at once
        send_item(32'hFFFF_FFFF, 11'd0);
        send_item(32'h0000_0000, 11'd0);
        send_item(32'h0000_0001, 11'd0);
        send_item(32'h0000_0001, 11'd0);        // equal sample folds
        send_item(32'h8000_0000, 11'd1);        // head leaves
        send_item(32'h7FFF_FFFF, 11'd0);
        send_item(32'h5555_5555, 11'd0);
        send_item(32'hAAAA_AAAA, 11'd2);        // drop ends inside a run
        send_item(32'h0000_0010, 11'd1024);     // drop too large
        send_item(32'h0000_0005, 11'd0);
        send_item(32'h0000_0004, 11'd0);
        send_item(32'h0000_0003, 11'd0);
        send_item(32'h0000_0002, 11'd682);
        send_item(32'h0000_0009, 11'd0);
        send_item(32'h0000_0008, 11'd341);
        send_item(32'h0000_0007, 11'd0);
        send_item(32'h0000_0007, 11'd3);        // fold then a drop past the held count empties
    endtask

    // bursts of random shapes: falling runs, narrow ranges with ties, wide values, small random steps
    task automatic test_random_windows(input int unsigned count);
        int unsigned         sent;
        int unsigned         run_len;
        int unsigned         shape;
        logic [SAMPLE_W-1:0] value;
        logic [DROP_W-1:0]   drop;
        sent = 0;
        while (sent < count)
        begin
            shape   = $urandom_range(0, 3);
            run_len = $urandom_range(1, 60);
            value   = $urandom;
            repeat (run_len)
            begin
                case (shape)
                    0:       value = value - $urandom_range(1, 1000);
                    1:       value = $urandom_range(0, 7);
                    2:       value = $urandom;
                    default: value = value + $urandom_range(0, 3) - 1;
                endcase
                if ($urandom_range(0, 19) == 0)
                    drop = DROP_W'($urandom_range(0, 1024));
                else if (q_held > 900)
                    drop = DROP_W'($urandom_range(2, 40));
                else
                    drop = DROP_W'($urandom_range(0, 2));
                send_item(value, drop);
                sent++;
            end
            if ($urandom_range(0, 15) == 0)
                pause_sender();
        end
    endtask

    // fill to the limit, then items are refused until reset; so this runs last
    task automatic test_overflow();
        logic [SAMPLE_W-1:0] value;
        value = 32'hFFFF_FFF0;
        while (q_held < LIMIT)
        begin
            value = ($urandom_range(0, 1) == 0) ? value - $urandom_range(0, 9)
                                                : $urandom;
            send_item(value, 11'd0);
        end
        repeat (6)
            send_item($urandom, DROP_W'($urandom_range(0, 1024)));
    endtask

    initial
    begin
        rst_n              = 1'b0;
        samples.valid      = 1'b0;
        samples.sample     = '0;
        samples.drop_count = '0;
        items_sent         = 0;
        results_seen       = 0;
        overflows_seen     = 0;
        empties_seen       = 0;
        errors             = 0;
        idle_cycles        = 0;
        burst_left         = 0;
        q_head             = 0;
        q_tail             = 0;
        q_entries          = 0;
        q_held             = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        pause_sender();
        test_random_windows(600);
        test_overflow();

        samples.valid <= 1'b0;
        while (expected_windows.size() != 0)
            @(posedge clk);
        repeat (LIMIT + 20) @(posedge clk);

        $display("tb: %0d items sent, %0d results checked", items_sent, results_seen);
        $display("tb: %0d empty windows, %0d refused items", empties_seen, overflows_seen);
        if (errors == 0 && expected_windows.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
rtl/swmq_pkg.sv
rtl/swmq_if.sv
rtl/swmq_cell.sv
rtl/sliding_window_max_queue_core.sv
bench/tb.sv
